// ----- design/c8ie_pkg.sv -----
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared constants, state encoding and controller/datapath bundles for the
// chip8 instruction executor.
// ----------------------------------------------------------------------------
package c8ie_pkg;

  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned LoadAddr   = 512;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned ScreenW    = 64;
  localparam int unsigned ScreenH    = 32;

  localparam int unsigned AddrW   = $clog2(MemBytes);
  localparam int unsigned SpW     = $clog2(StackDepth + 1);
  localparam int unsigned SpIdxW  = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned VidIdxW = $clog2(ScreenW * ScreenH / 8);
  localparam int unsigned VidBytes = ScreenW * ScreenH / 8;

  // step modes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_VREAD = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // result codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_HALTED  = 2'd2,
    ST_STACK   = 2'd3
  } status_e;

  // opcode groups and fixed words
  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SEI   = 4'h3;
  localparam logic [3:0] GRP_SNEI  = 4'h4;
  localparam logic [3:0] GRP_SER   = 4'h5;
  localparam logic [3:0] GRP_LDI   = 4'h6;
  localparam logic [3:0] GRP_ADDI  = 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SNER  = 4'h9;
  localparam logic [3:0] GRP_LDIDX = 4'hA;
  localparam logic [3:0] GRP_RND   = 4'hC;
  localparam logic [3:0] GRP_DRAW  = 4'hD;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRMEM,
    S_VREAD,
    S_VWAIT,
    S_FETCH_HI,
    S_FETCH_LO,
    S_FETCH_W,
    S_RD_X,
    S_RD_Y,
    S_EXEC,
    S_DR_ROW,
    S_DR_WA,
    S_DR_RB,
    S_DR_WB,
    S_DR_END,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_wr;
    logic rd_pc;
    logic rd_pc1;
    logic cap_hi;
    logic cap_lo;
    logic ld_vx;
    logic ld_vy;
    logic exec;
    logic set_halt;
    logic vid_cap;
    logic dr_rd_a;
    logic dr_wr_a;
    logic dr_rd_b;
    logic dr_wr_b;
    logic dr_next;
    logic dr_end;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halt;
    logic is_draw;
    logic row_done;
    logic need_b;
  } stat_t;

endpackage

// ----- design/c8ie_ctrl.sv -----
// ----------------------------------------------------------------------------
// c8ie_ctrl
// Sequencer for one step: memory write, video read, empty step, or fetch/
// decode/execute with the sprite drawing row loop, plus the output handshake.
// ----------------------------------------------------------------------------
module c8ie_ctrl
  import c8ie_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic [1:0]         s_mode_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  input  c8ie_pkg::stat_t    stat_i,
  output c8ie_pkg::cmd_t     cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_e'(s_mode_i))
            MODE_WRITE: state_d = S_WRMEM;
            MODE_EXEC:  state_d = S_FETCH_HI;
            MODE_VREAD: state_d = S_VREAD;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_WRMEM:    state_d = S_DONE;
      S_VREAD:    state_d = S_VWAIT;
      S_VWAIT:    state_d = S_DONE;
      S_FETCH_HI: state_d = stat_i.halt ? S_DONE : S_FETCH_LO;
      S_FETCH_LO: state_d = S_FETCH_W;
      S_FETCH_W:  state_d = S_RD_X;
      S_RD_X:     state_d = S_RD_Y;
      S_RD_Y:     state_d = S_EXEC;
      S_EXEC:     state_d = stat_i.is_draw ? S_DR_ROW : S_DONE;
      S_DR_ROW:   state_d = stat_i.row_done ? S_DR_END : S_DR_WA;
      S_DR_WA:    state_d = stat_i.need_b ? S_DR_RB : S_DR_ROW;
      S_DR_RB:    state_d = S_DR_WB;
      S_DR_WB:    state_d = S_DR_ROW;
      S_DR_END:   state_d = S_DONE;
      S_DONE:     if (!out_valid_q || m_tready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:     cmd_o.capture = accept;
      S_WRMEM:    cmd_o.mem_wr = 1'b1;
      S_VREAD:    cmd_o.dr_rd_a = 1'b0;
      S_VWAIT:    cmd_o.vid_cap = 1'b1;
      S_FETCH_HI: begin
        cmd_o.set_halt = stat_i.halt;
        cmd_o.rd_pc    = 1'b1;
      end
      S_FETCH_LO: begin
        cmd_o.cap_hi = 1'b1;
        cmd_o.rd_pc1 = 1'b1;
      end
      S_FETCH_W:  cmd_o.cap_lo = 1'b1;
      S_RD_X:     cmd_o.ld_vx = 1'b1;
      S_RD_Y:     cmd_o.ld_vy = 1'b1;
      S_EXEC:     cmd_o.exec = 1'b1;
      S_DR_ROW:   cmd_o.dr_rd_a = 1'b1;
      S_DR_WA: begin
        cmd_o.dr_wr_a = 1'b1;
        cmd_o.dr_next = !stat_i.need_b;
      end
      S_DR_RB:    cmd_o.dr_rd_b = 1'b1;
      S_DR_WB: begin
        cmd_o.dr_wr_b = 1'b1;
        cmd_o.dr_next = 1'b1;
      end
      S_DR_END:   cmd_o.dr_end = 1'b1;
      S_DONE:     cmd_o.load_out = !out_valid_q || m_tready_i;
      default:    cmd_o = '0;
    endcase
  end

  // output item valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_tready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/c8ie_datapath.sv -----
// ----------------------------------------------------------------------------
// c8ie_datapath
// Main memory, frame buffer, register file, return stack, execute logic and
// the output item register.
// ----------------------------------------------------------------------------
module c8ie_datapath
  import c8ie_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  c8ie_pkg::cmd_t                cmd_i,
  output c8ie_pkg::stat_t               stat_o,
  input  logic [c8ie_pkg::AddrW-1:0]    in_addr_i,
  input  logic [7:0]                    in_data_i,
  input  logic [6:0]                    in_rnd_i,
  input  logic [c8ie_pkg::AddrW-1:0]    rom_len_i,
  output logic [1:0]                    out_status_o,
  output logic [c8ie_pkg::AddrW-1:0]    out_pc_o,
  output logic [15:0]                   out_opcode_o,
  output logic [7:0]                    out_rdata_o
);

  // main memory, undefined until written
  logic [7:0] main_mem [MemBytes];
  logic [7:0] mem_q;
  logic [AddrW-1:0] mem_raddr;

  // frame buffer as bytes of eight pixels, with per-byte valid bits
  logic [7:0] fb_mem [VidBytes];
  logic [VidBytes-1:0] fb_valid_q;
  logic [7:0] fb_q;
  logic fbv_q;
  logic [VidIdxW-1:0] fb_addr, fb_idx_a;
  logic fb_we;
  logic [7:0] fb_wdata;
  logic [7:0] fb_old;

  logic [7:0] regs_q [16];
  logic [SpIdxW-1:0] stack_rd_idx;
  logic [AddrW-1:0] stack_mem [StackDepth];

  logic [AddrW-1:0] pc_q, i_q, in_addr_q;
  logic [SpW-1:0] sp_q;
  logic [7:0] data_q, hi_q, vx_q, vy_q, line_q;
  logic [6:0] rnd_q;
  logic [15:0] op_q;
  logic [1:0] status_q;
  logic [7:0] rd_q;
  logic [3:0] row_q;
  logic coll_q;

  logic [3:0] grp, ox, oy, on;
  logic [7:0] nn;
  logic [AddrW-1:0] nnn, pc_p2;
  logic [5:0] row_sum;
  logic [15:0] spr_a, spr_b;
  logic [8:0] sum9;
  logic [AddrW:0] rom_end;

  assign grp   = op_q[15:12];
  assign ox    = op_q[11:8];
  assign oy    = op_q[7:4];
  assign on    = op_q[3:0];
  assign nn    = op_q[7:0];
  assign nnn   = op_q[AddrW-1:0];
  assign pc_p2 = pc_q + AddrW'(2);

  // halt test against the end of the loaded program
  assign rom_end     = (AddrW+1)'(LoadAddr) + {1'b0, rom_len_i};
  assign stat_o.halt = {1'b0, pc_q} > rom_end;
  assign stat_o.is_draw = (grp == GRP_DRAW);

  // sprite geometry: row clip and second byte when straddling, column clip
  assign row_sum         = {1'b0, vy_q[4:0]} + {2'b00, row_q};
  assign stat_o.row_done = (row_q == on) || (row_sum >= 6'(ScreenH));
  assign stat_o.need_b   = (vx_q[2:0] != 3'd0) && (vx_q[5:3] != 3'd7);
  assign fb_idx_a        = {row_sum[4:0], vx_q[5:3]};
  assign spr_a           = {mem_q, 8'h00} >> vx_q[2:0];
  assign spr_b           = {line_q, 8'h00} >> vx_q[2:0];
  assign fb_old          = fbv_q ? fb_q : 8'h00;

  // main memory port
  always_comb begin
    if (cmd_i.rd_pc) mem_raddr = pc_q;
    else if (cmd_i.rd_pc1) mem_raddr = pc_q + AddrW'(1);
    else mem_raddr = i_q + AddrW'(row_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) main_mem[in_addr_q] <= data_q;
    mem_q <= main_mem[mem_raddr];
  end

  // frame buffer port
  always_comb begin
    if (cmd_i.dr_rd_a || cmd_i.dr_wr_a) fb_addr = fb_idx_a;
    else if (cmd_i.dr_rd_b || cmd_i.dr_wr_b) fb_addr = fb_idx_a + VidIdxW'(1);
    else fb_addr = in_addr_q[VidIdxW-1:0];
    fb_we    = cmd_i.dr_wr_a || cmd_i.dr_wr_b;
    fb_wdata = cmd_i.dr_wr_a ? (fb_old ^ spr_a[15:8]) : (fb_old ^ spr_b[7:0]);
  end

  always_ff @(posedge clk_i) begin
    if (fb_we) fb_mem[fb_addr] <= fb_wdata;
    fb_q <= fb_mem[fb_addr];
  end

  // return stack
  assign stack_rd_idx = SpIdxW'(sp_q - SpW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && grp == GRP_CALL && sp_q < SpW'(StackDepth))
      stack_mem[sp_q[SpIdxW-1:0]] <= pc_q;
  end

  assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};

  // architectural state and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) regs_q[k] <= 8'h00;
      fb_valid_q <= '0;
      fbv_q      <= 1'b0;
      pc_q       <= AddrW'(LoadAddr);
      i_q        <= '0;
      sp_q       <= '0;
      in_addr_q  <= '0;
      data_q     <= '0;
      rnd_q      <= '0;
      hi_q       <= '0;
      op_q       <= '0;
      vx_q       <= '0;
      vy_q       <= '0;
      line_q     <= '0;
      status_q   <= ST_DONE;
      rd_q       <= '0;
      row_q      <= '0;
      coll_q     <= 1'b0;
      out_status_o <= '0;
      out_pc_o     <= '0;
      out_opcode_o <= '0;
      out_rdata_o  <= '0;
    end else begin
      fbv_q <= fb_valid_q[fb_addr];
      if (fb_we) fb_valid_q[fb_addr] <= 1'b1;

      // latch the input item
      if (cmd_i.capture) begin
        in_addr_q <= in_addr_i;
        data_q    <= in_data_i;
        rnd_q     <= in_rnd_i;
        op_q      <= '0;
        rd_q      <= '0;
        status_q  <= ST_DONE;
      end
      if (cmd_i.vid_cap) rd_q <= fb_old;
      if (cmd_i.set_halt) status_q <= ST_HALTED;

      // fetch
      if (cmd_i.cap_hi) hi_q <= mem_q;
      if (cmd_i.cap_lo) begin
        op_q <= {hi_q, mem_q};
        pc_q <= pc_p2;
      end
      if (cmd_i.ld_vx) vx_q <= regs_q[ox];
      if (cmd_i.ld_vy) vy_q <= regs_q[oy];

      // execute
      if (cmd_i.exec) begin
        row_q  <= '0;
        coll_q <= 1'b0;
        case (grp)
          GRP_SYS: begin
            if (op_q == OP_CLS) fb_valid_q <= '0;
            else if (op_q == OP_RET) begin
              if (sp_q == '0 || sp_q > SpW'(StackDepth)) status_q <= ST_STACK;
              else begin
                sp_q <= sp_q - SpW'(1);
                pc_q <= stack_mem[stack_rd_idx];
              end
            end else status_q <= ST_UNKNOWN;
          end
          GRP_JP: pc_q <= nnn;
          GRP_CALL: begin
            if (sp_q >= SpW'(StackDepth)) status_q <= ST_STACK;
            else begin
              sp_q <= sp_q + SpW'(1);
              pc_q <= nnn;
            end
          end
          GRP_SEI:  if (vx_q == nn) pc_q <= pc_p2;
          GRP_SNEI: if (vx_q != nn) pc_q <= pc_p2;
          GRP_SER:  if (vx_q == vy_q) pc_q <= pc_p2;
          GRP_SNER: if (vx_q != vy_q) pc_q <= pc_p2;
          GRP_LDI:  regs_q[ox] <= nn;
          GRP_ADDI: regs_q[ox] <= vx_q + nn;
          GRP_LDIDX: i_q <= nnn;
          GRP_RND:  regs_q[ox] <= nn & {1'b0, rnd_q};
          GRP_DRAW: ;
          GRP_ALU: begin
            case (on)
              ALU_MOV: regs_q[ox] <= vy_q;
              ALU_OR:  regs_q[ox] <= vx_q | vy_q;
              ALU_AND: regs_q[ox] <= vx_q & vy_q;
              ALU_XOR: regs_q[ox] <= vx_q ^ vy_q;
              ALU_ADD: begin
                regs_q[ox] <= sum9[7:0];
                regs_q[15] <= {7'd0, sum9[8]};
              end
              ALU_SUB: begin
                regs_q[ox] <= vx_q - vy_q;
                regs_q[15] <= {7'd0, vx_q >= vy_q};
              end
              ALU_SHR: begin
                regs_q[ox] <= {1'b0, vy_q[7:1]};
                regs_q[15] <= {7'd0, vy_q[0]};
              end
              ALU_SUBN: begin
                regs_q[ox] <= vy_q - vx_q;
                regs_q[15] <= {7'd0, vy_q >= vx_q};
              end
              ALU_SHL: begin
                regs_q[ox] <= {vy_q[6:0], 1'b0};
                regs_q[15] <= {7'd0, vy_q[7]};
              end
              default: status_q <= ST_UNKNOWN;
            endcase
          end
          default: status_q <= ST_UNKNOWN;
        endcase
      end

      // sprite row loop
      if (cmd_i.dr_wr_a) begin
        line_q <= mem_q;
        if ((fb_old & spr_a[15:8]) != 8'h00) coll_q <= 1'b1;
      end
      if (cmd_i.dr_wr_b && (fb_old & spr_b[7:0]) != 8'h00) coll_q <= 1'b1;
      if (cmd_i.dr_next) row_q <= row_q + 4'd1;
      if (cmd_i.dr_end) regs_q[15] <= {7'd0, coll_q};

      // output item register
      if (cmd_i.load_out) begin
        out_status_o <= status_q;
        out_pc_o     <= pc_q;
        out_opcode_o <= op_q;
        out_rdata_o  <= rd_q;
      end
    end
  end

endmodule

// ----- design/chip8_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_executor
// A chip8 core stepped one item at a time by a host: it writes memory bytes,
// executes one instruction, or reads eight video pixels, and returns one
// result item per input item; mode 3 only returns a result. A sprite draw
// reads and writes the single-port frame buffer byte of each row, and the
// next video byte as well for a row that straddles two bytes, then closes
// the row loop.
// The next input item is taken while the previous result waits on the output.
// rom_length sits at address 0 of the register port.
// ----------------------------------------------------------------------------
module chip8_instruction_executor
  import c8ie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // address[11:0], data[19:12], random_value[26:20]
  input  logic [1:0]  s_tuser_i,   // mode[1:0]
  // result item
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // status[1:0], next_pc[13:2],
                                   // fetched_opcode[29:14], read_data[37:30]
  // register port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  cmd_t  cmd;
  stat_t stat;
  logic [AddrW-1:0] rom_len_q;
  logic [1:0]       out_status;
  logic [AddrW-1:0] out_pc;
  logic [15:0]      out_opcode;
  logic [7:0]       out_rdata;

  // register port
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == 2'd0) ? {{(32-AddrW){1'b0}}, rom_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_len_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && pready_o && paddr_i == 2'd0) begin
      rom_len_q <= pwdata_i[AddrW-1:0];
    end
  end

  c8ie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_mode_i   (s_tuser_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  c8ie_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_addr_i    (s_tdata_i[11:0]),
    .in_data_i    (s_tdata_i[19:12]),
    .in_rnd_i     (s_tdata_i[26:20]),
    .rom_len_i    (rom_len_q),
    .out_status_o (out_status),
    .out_pc_o     (out_pc),
    .out_opcode_o (out_opcode),
    .out_rdata_o  (out_rdata)
  );

  // result packing
  assign m_tdata_o = {2'b00, out_rdata, out_opcode, out_pc, out_status};

endmodule

// ----- sim/chip8_instruction_executor_tb.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_executor_tb
// Steps the core with memory writes, single instructions and video reads over
// the stream ports, predicts every result item from its own copy of memory,
// display, registers and stack, and compares each field. The run goes through
// several program lengths written over the register port, from zero to full.
// ----------------------------------------------------------------------------
module chip8_instruction_executor_tb;
  import c8ie_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // low memory window that holds sprite data
  localparam int FillLen = 128;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] pc;
    logic [15:0] opcode;
    logic [7:0]  pixels;
  } step_res_t;

  typedef struct {
    mode_e       mode;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [6:0]  rnd;
    bit          typed;
    step_res_t   res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i = '0;   // address[11:0], data[19:12], random_value[26:20]
  logic [1:0]  s_tuser_i = '0;   // mode[1:0]
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [39:0] m_tdata_o;        // status[1:0], next_pc[13:2],
                                 // fetched_opcode[29:14], read_data[37:30]
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [1:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  chip8_instruction_executor DUT (.*);

  // model state of the core
  logic [7:0]  mem_img [MemBytes];
  bit          pix_img [ScreenW * ScreenH];
  logic [7:0]  vreg [16];
  logic [11:0] idx_reg;
  logic [11:0] pc_reg = 12'(LoadAddr);
  logic [11:0] call_stack [StackDepth];
  int          depth;
  logic [11:0] rom_len;

  step_res_t   pending_res [$];
  int          fail_cnt;
  bit          idle_on = 1'b1;
  int          call_wt = 1;

  initial begin
    foreach (mem_img[i]) mem_img[i] = '0;
    foreach (pix_img[i]) pix_img[i] = 1'b0;
    foreach (vreg[i]) vreg[i] = '0;
    idx_reg = '0;
    depth = 0;
    rom_len = '0;
    fail_cnt = 0;
  end

  // clock and reset
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sprite draw with clipping, collision into VF
  function automatic void draw(logic [3:0] x, logic [3:0] y, logic [3:0] rows);
    int x0, y0, p;
    logic [7:0] line;
    x0 = vreg[x] % ScreenW;
    y0 = vreg[y] % ScreenH;
    vreg[15] = 8'd0;
    for (int r = 0; r < rows; r++) begin
      line = mem_img[12'(idx_reg + r)];
      if (y0 + r >= ScreenH) break;
      for (int b = 0; b < 8; b++) begin
        if (x0 + b >= ScreenW) break;
        if (line[7-b]) begin
          p = (y0 + r) * ScreenW + x0 + b;
          if (pix_img[p]) vreg[15] = 8'd1;
          pix_img[p] = ~pix_img[p];
        end
      end
    end
  endfunction

  // 8XYn group, flag written last
  function automatic logic [1:0] alu_op(logic [3:0] x, logic [3:0] y, logic [3:0] n);
    logic [7:0] vx, vy, flag;
    logic [8:0] sum;
    vx = vreg[x];
    vy = vreg[y];
    case (n)
      ALU_MOV: begin vreg[x] = vy; return ST_DONE; end
      ALU_OR:  begin vreg[x] = vx | vy; return ST_DONE; end
      ALU_AND: begin vreg[x] = vx & vy; return ST_DONE; end
      ALU_XOR: begin vreg[x] = vx ^ vy; return ST_DONE; end
      ALU_ADD: begin
        sum = vx + vy;
        flag = {7'd0, sum[8]};
        vreg[x] = sum[7:0];
      end
      ALU_SUB: begin
        flag = {7'd0, vx >= vy};
        vreg[x] = vx - vy;
      end
      ALU_SHR: begin
        flag = {7'd0, vy[0]};
        vreg[x] = vy >> 1;
      end
      ALU_SUBN: begin
        flag = {7'd0, vy >= vx};
        vreg[x] = vy - vx;
      end
      ALU_SHL: begin
        flag = {7'd0, vy[7]};
        vreg[x] = vy << 1;
      end
      default: return ST_UNKNOWN;
    endcase
    vreg[15] = flag;
    return ST_DONE;
  endfunction

  function automatic logic [1:0] run_insn(logic [15:0] op);
    logic [3:0] x, y, n;
    logic [7:0] nn;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    case (op[15:12])
      GRP_SYS: begin
        if (op == OP_CLS) begin
          foreach (pix_img[i]) pix_img[i] = 1'b0;
          return ST_DONE;
        end
        if (op == OP_RET) begin
          if (depth == 0) return ST_STACK;
          depth--;
          pc_reg = call_stack[depth];
          return ST_DONE;
        end
        return ST_UNKNOWN;
      end
      GRP_JP: pc_reg = op[11:0];
      GRP_CALL: begin
        if (depth >= StackDepth) return ST_STACK;
        call_stack[depth] = pc_reg;
        depth++;
        pc_reg = op[11:0];
      end
      GRP_SEI:   if (vreg[x] == nn) pc_reg = pc_reg + 12'd2;
      GRP_SNEI:  if (vreg[x] != nn) pc_reg = pc_reg + 12'd2;
      GRP_SER:   if (vreg[x] == vreg[y]) pc_reg = pc_reg + 12'd2;
      GRP_LDI:   vreg[x] = nn;
      GRP_ADDI:  vreg[x] = vreg[x] + nn;
      GRP_ALU:   return alu_op(x, y, n);
      GRP_SNER:  if (vreg[x] != vreg[y]) pc_reg = pc_reg + 12'd2;
      GRP_LDIDX: idx_reg = op[11:0];
      GRP_DRAW:  draw(x, y, n);
      default:   return ST_UNKNOWN;
    endcase
    return ST_DONE;
  endfunction

  // one step of the core
  function automatic step_res_t predict_step(mode_e mode, logic [11:0] addr,
                                             logic [7:0] data, logic [6:0] rnd);
    step_res_t res;
    res = '0;
    case (mode)
      MODE_WRITE: mem_img[addr] = data;
      MODE_VREAD: begin
        for (int b = 0; b < 8; b++)
          res.pixels[7-b] = pix_img[addr[7:0] * 8 + b];
      end
      MODE_EXEC: begin
        if ({1'b0, pc_reg} > 13'(LoadAddr) + rom_len) begin
          res.status = ST_HALTED;
        end else begin
          res.opcode = {mem_img[pc_reg], mem_img[12'(pc_reg + 1)]};
          pc_reg = pc_reg + 12'd2;
          if (res.opcode[15:12] == GRP_RND) begin
            vreg[res.opcode[11:8]] = res.opcode[7:0] & {1'b0, rnd};
            res.status = ST_DONE;
          end else begin
            res.status = run_insn(res.opcode);
          end
        end
      end
      default: ;
    endcase
    res.pc = pc_reg;
    return res;
  endfunction

  // send one item, with an optional idle burst ahead of it
  task automatic send_item(mode_e mode, logic [11:0] addr, logic [7:0] data,
                           logic [6:0] rnd, bit typed = 0, step_res_t want = '0);
    step_res_t got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= mode;
    s_tdata_i  <= {5'd0, rnd, data, addr};
    do @(posedge clk_i); while (!s_tready_o);
    got = predict_step(mode, addr, data, rnd);
    if (typed && got != want) begin
      $error("typed result differs: want %h model %h", want, got);
      fail_cnt++;
    end
    pending_res.push_back(got);
  endtask

  // write rom_length while idle
  task automatic set_rom_len(logic [11:0] len);
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= 2'd0;
    pwdata_i  <= {20'd0, len};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    rom_len = len;
  endtask

  // place an instruction at the program counter and execute it
  task automatic exec_op(logic [15:0] op, logic [6:0] rnd);
    logic [11:0] at;
    at = pc_reg;
    send_item(MODE_WRITE, at, op[15:8], 7'($urandom));
    send_item(MODE_WRITE, 12'(at + 1), op[7:0], 7'($urandom));
    send_item(MODE_EXEC, 12'($urandom), 8'($urandom), rnd);
  endtask

  function automatic logic [15:0] pick_op();
    int r;
    logic [15:0] op;
    r = $urandom_range(0, 11);
    op = 16'($urandom);
    if (r < call_wt) op[15:12] = GRP_CALL;
    else if (r == 4) op = OP_RET;
    else if (r == 5) op = OP_CLS;
    else if (op[15:12] == GRP_ALU && $urandom_range(0, 1)) op[3:0] = 4'($urandom_range(0, 7));
    // keep sprite reads inside the filled window
    if (op[15:12] == GRP_LDIDX) op[11:0] = 12'($urandom_range(0, FillLen - 16));
    return op;
  endfunction

  task automatic random_items(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r < 14) exec_op(pick_op(), 7'($urandom));
      else if (r < 15) send_item(MODE_WRITE, 12'($urandom), 8'($urandom), 7'($urandom));
      else if (r < 19) send_item(MODE_VREAD, 12'($urandom), 8'($urandom), 7'($urandom));
      else send_item(MODE_NOP, 12'($urandom), 8'($urandom), 7'($urandom));
    end
  endtask

  // directed rows right after reset
  row_t boot_rows [6] = '{
    '{MODE_VREAD, 12'h000, 8'h00, 7'h00, 1, '{ST_DONE, 12'd512, 16'h0000, 8'h00}},
    '{MODE_NOP,   12'hFFF, 8'hFF, 7'h7F, 1, '{ST_DONE, 12'd512, 16'h0000, 8'h00}},
    '{MODE_WRITE, 12'd512, 8'h00, 7'h00, 1, '{ST_DONE, 12'd512, 16'h0000, 8'h00}},
    '{MODE_WRITE, 12'd513, 8'hE0, 7'h7F, 1, '{ST_DONE, 12'd512, 16'h0000, 8'h00}},
    '{MODE_EXEC,  12'h000, 8'h00, 7'h00, 1, '{ST_DONE, 12'd514, OP_CLS,   8'h00}},
    '{MODE_EXEC,  12'hFFF, 8'hFF, 7'h7F, 1, '{ST_HALTED, 12'd514, 16'h0000, 8'h00}}
  };

  // directed instructions: flag as target, left shift, full draw, underflow,
  // random mask, unknown opcode, clear
  logic [15:0] insn_rows [8] = '{16'h6FFF, 16'h8FF4, 16'h80FE, 16'hD01F,
                                 OP_RET, 16'hC0FF, 16'hF000, OP_CLS};

  // result checker
  always @(posedge clk_i) begin
    step_res_t want, got;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.status = m_tdata_o[1:0];
      got.pc     = m_tdata_o[13:2];
      got.opcode = m_tdata_o[29:14];
      got.pixels = m_tdata_o[37:30];
      if (pending_res.size() == 0) begin
        $error("result item with none expected: %h", got);
        fail_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status);
          fail_cnt++;
        end
        if (got.pc != want.pc) begin
          $error("next_pc: expected %h actual %h", want.pc, got.pc);
          fail_cnt++;
        end
        if (got.opcode != want.opcode) begin
          $error("fetched_opcode: expected %h actual %h", want.opcode, got.opcode);
          fail_cnt++;
        end
        if (got.pixels != want.pixels) begin
          $error("read_data: expected %h actual %h", want.pixels, got.pixels);
          fail_cnt++;
        end
      end
    end
  end

  // result-side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // stimulus
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    set_rom_len(12'd0);
    foreach (boot_rows[i])
      send_item(boot_rows[i].mode, boot_rows[i].addr, boot_rows[i].data,
                boot_rows[i].rnd, boot_rows[i].typed, boot_rows[i].res);
    // fill the sprite window; every fetch goes through a fresh write
    for (int a = 0; a < FillLen; a++)
      send_item(MODE_WRITE, 12'(a), 8'($urandom), 7'($urandom));
    set_rom_len(12'd3584);
    foreach (insn_rows[i]) exec_op(insn_rows[i], 7'h7F);
    send_item(MODE_VREAD, 12'hF00, 8'h00, 7'h00);
    random_items(80);
    set_rom_len(12'($urandom_range(0, 3584)));
    random_items(40);
    set_rom_len(12'd3584);
    call_wt = 3;
    random_items(50);
    idle_on = 1'b0;
    random_items(30);
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && pending_res.size() == 0) begin
      $display("chip8_instruction_executor: match");
    end else begin
      $display("chip8_instruction_executor: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #4ms;
    $display("chip8_instruction_executor: mismatch");
    $finish;
  end

endmodule
